[hw/rtl/hfa_pkg.sv]
// Shared types, constants and SHA-256 helpers for the HMAC frame authenticator.
package hfa_pkg;

    localparam int MAX_FRAME_BYTES_DEF = 2048;
    localparam int TAG_BYTES_DEF       = 16;
    localparam int HDR_BYTES           = 6;
    localparam int BLOCK_BYTES         = 64;
    localparam int DIGEST_BYTES        = 32;
    localparam int PAD_LEN_POS         = 56;
    localparam int COUNT_W             = 12;
    localparam int FILL_W              = 7;
    localparam int ROUND_W             = 6;
    localparam int OUTER_LEN_BITS      = (BLOCK_BYTES + DIGEST_BYTES) * 8;

    localparam logic [7:0] IPAD     = 8'h36;
    localparam logic [7:0] OPAD     = 8'h5C;
    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [1:0] CFG_KEY_HIGH   = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW    = 2'd1;
    localparam logic [1:0] CFG_SEQ_WINDOW = 2'd2;

    localparam logic [2:0] RSN_OK    = 3'd0;
    localparam logic [2:0] RSN_SHORT = 3'd1;
    localparam logic [2:0] RSN_LONG  = 3'd2;
    localparam logic [2:0] RSN_TAG   = 3'd3;
    localparam logic [2:0] RSN_INDEX = 3'd4;
    localparam logic [2:0] RSN_SEQ   = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROUTE,
        S_KEY,
        S_DIGEST,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_SAVE,
        S_CHECK,
        S_VERDICT
    } hfa_state_t;

    typedef enum logic [2:0] {
        PH_DATA,
        PH_KEYIN,
        PH_PADIN,
        PH_KEYOUT,
        PH_PADOUT
    } hfa_phase_t;

    typedef struct packed {
        logic               frame_byte;
        logic               load_seq;
        logic               h_init;
        logic               gen_key;
        logic               gen_digest;
        logic               gen_pad;
        logic               round_start;
        logic               round_step;
        logic               h_add;
        logic               save_digest;
        logic               outer;
        logic               verdict;
        logic [ROUND_W-1:0] round_idx;
    } hfa_cmd_t;

    typedef struct packed {
        logic              count_zero;
        logic              frame_short;
        logic              overlength;
        logic              overflow;
        logic              out_busy;
        logic [FILL_W-1:0] fill;
    } hfa_status_t;

    localparam logic [31:0] SHA_IV [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
    endfunction

endpackage

[hw/rtl/hmac_frame_authenticator_unit.sv]
// Top level of the HMAC-SHA-256 frame authenticator.
//
// Frame bytes and set-sequence requests enter on the in_* valid/ready channel;
// one verdict per frame leaves on the out_* channel after the last byte.
// Configuration (key halves, sequence window) is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle,
// which the block does not enforce. Each frame byte is accepted, then routed.
// Every 64 hashed bytes the shared SHA-256 round unit runs (load, 64 rounds,
// add), and the first byte of a frame starts the keyed inner block. After
// the last byte the inner padding, the outer keyed block and the outer digest
// block are hashed before the verdict register is loaded; frames that are too
// short or too long skip this hashing and go straight to the verdict.
// A set-sequence request is taken while idle and gives no verdict.
// Reset clears the keys, window, counters and frame state.
// While the receiver stalls, the verdict waits in its output register and
// byte intake continues; a second verdict waits until the first is taken.
module hmac_frame_authenticator_unit
    import hfa_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int TAG_BYTES       = TAG_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        last,
    input  logic [31:0] new_sequence,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        accepted,
    output logic [2:0]  reject_reason,
    output logic [15:0] security_index,
    output logic [31:0] received_sequence,
    output logic [31:0] expected_sequence,
    output logic [31:0] accepted_total,
    output logic [31:0] rejected_total
);

    hfa_cmd_t    cmd;
    hfa_status_t status;

    hfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .command  (command),
        .last     (last),
        .status   (status),
        .cmd      (cmd)
    );

    hfa_datapath #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .TAG_BYTES       (TAG_BYTES)
    ) u_datapath (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .status            (status),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .data_byte         (data_byte),
        .new_sequence      (new_sequence),
        .out_ready         (out_ready),
        .out_valid         (out_valid),
        .accepted          (accepted),
        .reject_reason     (reject_reason),
        .security_index    (security_index),
        .received_sequence (received_sequence),
        .expected_sequence (expected_sequence),
        .accepted_total    (accepted_total),
        .rejected_total    (rejected_total)
    );

endmodule

[hw/rtl/hfa_ctrl.sv]
// Sequencer for byte intake, block generation and SHA-256 rounds.
module hfa_ctrl
    import hfa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic        last,
    input  hfa_status_t status,
    output hfa_cmd_t    cmd
);

    localparam logic [FILL_W-1:0]  FILL_BLOCK  = FILL_W'(BLOCK_BYTES);
    localparam logic [FILL_W-1:0]  FILL_DIGEST = FILL_W'(DIGEST_BYTES);
    localparam logic [ROUND_W-1:0] ROUND_LAST  = '1;

    hfa_state_t         state_reg, state_next;
    hfa_phase_t         phase_reg, phase_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               start_pending_reg, start_pending_next;
    logic               last_pending_reg, last_pending_next;
    logic               take;

    assign take = (state_reg == S_IDLE) && in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            phase_reg         <= PH_DATA;
            round_reg         <= '0;
            start_pending_reg <= 1'b0;
            last_pending_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            phase_reg         <= phase_next;
            round_reg         <= round_next;
            start_pending_reg <= start_pending_next;
            last_pending_reg  <= last_pending_next;
        end
    end

    always_comb
    begin
        state_next         = state_reg;
        phase_next         = phase_reg;
        round_next         = round_reg;
        start_pending_next = start_pending_reg;
        last_pending_next  = last_pending_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (take && !command)
                begin
                    start_pending_next = status.count_zero;
                    last_pending_next  = last;
                    state_next         = S_ROUTE;
                end
            end
            S_ROUTE:
            begin
                // The keyed inner block is hashed right after the first byte of a frame.
                priority if (start_pending_reg)
                begin
                    start_pending_next = 1'b0;
                    phase_next         = PH_KEYIN;
                    state_next         = S_KEY;
                end
                else if (status.fill == FILL_BLOCK)
                    state_next = S_LOAD;
                else if (last_pending_reg)
                    state_next = S_CHECK;
                else
                    state_next = S_IDLE;
            end
            S_KEY:
            begin
                if (status.fill == FILL_BLOCK)
                    state_next = S_LOAD;
            end
            S_DIGEST:
            begin
                if (status.fill == FILL_DIGEST)
                    state_next = S_PAD;
            end
            S_PAD:
            begin
                if (status.fill == FILL_BLOCK)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                round_next = '0;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                round_next = round_reg + 1'b1;
                if (round_reg == ROUND_LAST)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                unique case (phase_reg)
                    PH_KEYIN:
                    begin
                        phase_next = PH_DATA;
                        state_next = S_ROUTE;
                    end
                    PH_DATA:
                        state_next = S_ROUTE;
                    PH_PADIN:
                        state_next = status.overflow ? S_PAD : S_SAVE;
                    PH_KEYOUT:
                    begin
                        phase_next = PH_PADOUT;
                        state_next = S_DIGEST;
                    end
                    PH_PADOUT:
                        state_next = S_VERDICT;
                    default:
                        state_next = S_IDLE;
                endcase
            end
            S_SAVE:
            begin
                phase_next = PH_KEYOUT;
                state_next = S_KEY;
            end
            S_CHECK:
            begin
                if (status.frame_short || status.overlength)
                    state_next = S_VERDICT;
                else
                begin
                    phase_next = PH_PADIN;
                    state_next = S_PAD;
                end
            end
            S_VERDICT:
            begin
                if (!status.out_busy)
                begin
                    last_pending_next = 1'b0;
                    phase_next        = PH_DATA;
                    state_next        = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = (state_reg == S_IDLE);
        cmd             = '0;
        cmd.frame_byte  = take && !command;
        cmd.load_seq    = take && command;
        cmd.h_init      = ((state_reg == S_ROUTE) && start_pending_reg) || (state_reg == S_SAVE);
        cmd.gen_key     = (state_reg == S_KEY) && (status.fill != FILL_BLOCK);
        cmd.gen_digest  = (state_reg == S_DIGEST) && (status.fill != FILL_DIGEST);
        cmd.gen_pad     = (state_reg == S_PAD) && (status.fill != FILL_BLOCK);
        cmd.round_start = (state_reg == S_LOAD);
        cmd.round_step  = (state_reg == S_ROUND);
        cmd.h_add       = (state_reg == S_ADD);
        cmd.save_digest = (state_reg == S_SAVE);
        cmd.outer       = (phase_reg == PH_KEYOUT) || (phase_reg == PH_PADOUT);
        cmd.verdict     = (state_reg == S_VERDICT) && !status.out_busy;
        cmd.round_idx   = round_reg;
    end

endmodule

[hw/rtl/hfa_datapath.sv]
// Frame registers, message block, SHA-256 round unit and verdict logic.
module hfa_datapath
    import hfa_pkg::*;
#(
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int TAG_BYTES       = TAG_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  hfa_cmd_t    cmd,
    output hfa_status_t status,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic [7:0]  data_byte,
    input  logic [31:0] new_sequence,
    input  logic        out_ready,
    output logic        out_valid,
    output logic        accepted,
    output logic [2:0]  reject_reason,
    output logic [15:0] security_index,
    output logic [31:0] received_sequence,
    output logic [31:0] expected_sequence,
    output logic [31:0] accepted_total,
    output logic [31:0] rejected_total
);

    localparam int TAG_W = 8 * TAG_BYTES;
    localparam logic [COUNT_W-1:0] MAX_COUNT = COUNT_W'(MAX_FRAME_BYTES);
    localparam logic [COUNT_W-1:0] MIN_COUNT = COUNT_W'(HDR_BYTES + TAG_BYTES);
    localparam logic [COUNT_W-1:0] TAG_COUNT = COUNT_W'(TAG_BYTES);
    localparam logic [COUNT_W-1:0] IDX_END   = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] HDR_END   = COUNT_W'(HDR_BYTES);
    localparam logic [FILL_W-1:0]  FILL_LEN  = FILL_W'(PAD_LEN_POS);
    localparam logic [FILL_W-1:0]  FILL_KEY  = FILL_W'(16);

    logic [63:0]          key_high_reg, key_low_reg;
    logic [31:0]          window_reg;
    logic [31:0]          seq_exp_reg, acc_reg, rej_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [15:0]          hidx_reg;
    logic [31:0]          hseq_reg;
    logic                 overlen_reg;
    logic [FILL_W-1:0]    fill_reg;
    logic                 marker_reg, overflow_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [511:0]         msg_reg;
    logic [31:0]          h_reg [8];
    logic [31:0]          v_reg [8];
    logic [255:0]         dig_reg;
    logic                 out_valid_reg;

    logic                 in_range, hash_in, shift_in;
    logic [127:0]         key128;
    logic [7:0]           key_byte, pad_byte, len_byte, gen_byte;
    logic [12:0]          inner_units;
    logic [63:0]          len_bits;
    logic [31:0]          w_new, t1, t2;
    logic [255:0]         h_vec;
    logic                 tag_ok;
    logic [31:0]          seq_delta, seq_plus;
    logic [2:0]           reason;

    assign in_range = count_reg < MAX_COUNT;
    assign hash_in  = cmd.frame_byte && in_range && (count_reg >= TAG_COUNT);
    assign shift_in = hash_in || cmd.gen_key || cmd.gen_digest || cmd.gen_pad;

    // Key bytes beyond the 16-byte key are zero.
    assign key128   = {key_high_reg, key_low_reg};
    assign key_byte = (fill_reg < FILL_KEY) ? key128[{~fill_reg[3:0], 3'b000} +: 8] : 8'h00;

    assign inner_units = {1'b0, count_reg} + 13'(BLOCK_BYTES) - 13'(TAG_BYTES);
    assign len_bits    = cmd.outer ? 64'(OUTER_LEN_BITS) : {48'd0, inner_units, 3'b000};
    assign len_byte    = len_bits[{~fill_reg[2:0], 3'b000} +: 8];

    // When the marker lands in the last eight bytes, the length goes into one more block.
    always_comb
    begin
        priority if (!marker_reg)
            pad_byte = PAD_MARK;
        else if ((fill_reg >= FILL_LEN) && !overflow_reg)
            pad_byte = len_byte;
        else
            pad_byte = 8'h00;
    end

    always_comb
    begin
        priority if (cmd.gen_key)
            gen_byte = key_byte ^ (cmd.outer ? OPAD : IPAD);
        else if (cmd.gen_digest)
            gen_byte = dig_reg[255:248];
        else if (cmd.gen_pad)
            gen_byte = pad_byte;
        else
            gen_byte = tag_reg[TAG_W-1 -: 8];
    end

    assign w_new = msg_reg[511:480] + small_sigma0(msg_reg[479:448]) + msg_reg[223:192]
                 + small_sigma1(msg_reg[63:32]);
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + SHA_K[cmd.round_idx] + msg_reg[511:480];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    assign h_vec  = {h_reg[0], h_reg[1], h_reg[2], h_reg[3],
                     h_reg[4], h_reg[5], h_reg[6], h_reg[7]};
    assign tag_ok = (tag_reg == h_vec[255 -: TAG_W]);

    assign seq_delta = hseq_reg - seq_exp_reg;
    assign seq_plus  = hseq_reg + 32'd1;

    always_comb
    begin
        priority if (count_reg < MIN_COUNT)
            reason = RSN_SHORT;
        else if (overlen_reg)
            reason = RSN_LONG;
        else if (!tag_ok)
            reason = RSN_TAG;
        else if (hidx_reg != 16'd0)
            reason = RSN_INDEX;
        else if (seq_delta > window_reg)
            reason = RSN_SEQ;
        else
            reason = RSN_OK;
    end

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_high_reg  <= '0;
            key_low_reg   <= '0;
            window_reg    <= '0;
            seq_exp_reg   <= '0;
            acc_reg       <= '0;
            rej_reg       <= '0;
            count_reg     <= '0;
            hidx_reg      <= '0;
            hseq_reg      <= '0;
            overlen_reg   <= 1'b0;
            fill_reg      <= '0;
            marker_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_KEY_HIGH:   key_high_reg <= cfg_data;
                    CFG_KEY_LOW:    key_low_reg  <= cfg_data;
                    CFG_SEQ_WINDOW: window_reg   <= cfg_data[31:0];
                    default:        ;
                endcase
            end

            if (cmd.load_seq)
                seq_exp_reg <= new_sequence;

            if (cmd.frame_byte)
            begin
                if (in_range)
                begin
                    if (count_reg < IDX_END)
                        hidx_reg <= {hidx_reg[7:0], data_byte};
                    else if (count_reg < HDR_END)
                        hseq_reg <= {hseq_reg[23:0], data_byte};
                    count_reg <= count_reg + 1'b1;
                end
                else
                    overlen_reg <= 1'b1;
            end

            if (cmd.gen_pad && !marker_reg)
            begin
                marker_reg <= 1'b1;
                if (fill_reg >= FILL_LEN)
                    overflow_reg <= 1'b1;
            end

            if (cmd.h_add)
                overflow_reg <= 1'b0;

            priority if (cmd.h_init || cmd.round_start)
                fill_reg <= '0;
            else if (shift_in)
                fill_reg <= fill_reg + 1'b1;

            if (cmd.h_init)
            begin
                marker_reg   <= 1'b0;
                overflow_reg <= 1'b0;
            end

            if (cmd.verdict)
            begin
                if (reason == RSN_OK)
                begin
                    seq_exp_reg <= seq_plus;
                    acc_reg     <= acc_reg + 32'd1;
                end
                else
                    rej_reg <= rej_reg + 32'd1;
                count_reg    <= '0;
                overlen_reg  <= 1'b0;
                hidx_reg     <= '0;
                hseq_reg     <= '0;
                fill_reg     <= '0;
                marker_reg   <= 1'b0;
                overflow_reg <= 1'b0;
            end

            priority if (cmd.verdict)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.frame_byte && in_range)
            tag_reg <= {tag_reg[TAG_W-9:0], data_byte};

        priority if (cmd.round_step)
            msg_reg <= {msg_reg[479:0], w_new};
        else if (shift_in)
            msg_reg <= {msg_reg[503:0], gen_byte};

        if (cmd.gen_digest)
            dig_reg <= {dig_reg[247:0], 8'h00};
        else if (cmd.save_digest)
            dig_reg <= h_vec;

        for (int i = 0; i < 8; i++)
        begin
            if (cmd.h_init)
                h_reg[i] <= SHA_IV[i];
            else if (cmd.h_add)
                h_reg[i] <= h_reg[i] + v_reg[i];
        end

        if (cmd.round_start)
        begin
            for (int i = 0; i < 8; i++)
                v_reg[i] <= h_reg[i];
        end
        else if (cmd.round_step)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end

        if (cmd.verdict)
        begin
            accepted          <= (reason == RSN_OK);
            reject_reason     <= reason;
            security_index    <= hidx_reg;
            received_sequence <= hseq_reg;
            expected_sequence <= (reason == RSN_OK) ? seq_plus : seq_exp_reg;
            accepted_total    <= (reason == RSN_OK) ? acc_reg + 32'd1 : acc_reg;
            rejected_total    <= (reason == RSN_OK) ? rej_reg : rej_reg + 32'd1;
        end
    end

    assign out_valid = out_valid_reg;

    assign status.count_zero  = (count_reg == '0);
    assign status.frame_short = (count_reg < MIN_COUNT);
    assign status.overlength  = overlen_reg;
    assign status.overflow    = overflow_reg;
    assign status.out_busy    = out_valid_reg && !out_ready;
    assign status.fill        = fill_reg;

endmodule

[hw/rtl/hfa_checker.sv]
// Port-level checks for the frame authenticator and their bind.
module hfa_checker
    import hfa_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic        accepted,
    input logic [2:0]  reject_reason,
    input logic [31:0] received_sequence,
    input logic [31:0] expected_sequence,
    input logic [31:0] accepted_total,
    input logic [31:0] rejected_total
);

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reject_reason)
            && $stable(accepted_total) && $stable(rejected_total))
        else $error("verdict changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> accepted == (reject_reason == RSN_OK))
        else $error("accepted flag disagrees with reason");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && accepted |-> expected_sequence == received_sequence + 32'd1)
        else $error("expected sequence not advanced on acceptance");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> reject_reason <= RSN_SEQ)
        else $error("reject reason out of range");

endmodule

bind hmac_frame_authenticator_unit hfa_checker u_hfa_checker (.*);

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the HMAC-SHA-256 frame authenticator with its own SHA-256 model.
module tb_top;
    import hfa_pkg::*;

    localparam logic [1:0] CFG_UNUSED   = 2'd3;
    localparam int         FRAME_LIMIT  = 2048;
    localparam int         TAG_LEN      = 16;
    localparam int         MIN_FRAME    = 22;
    localparam int         RANDOM_ITEMS = 1450;
    localparam int         DRAIN_CYCLES = 600;
    localparam int         HOLD_CYCLES  = 3000;
    localparam int         STALL_LIMIT  = 20000;

    typedef enum {FR_GOOD, FR_BAD_TAG, FR_BAD_INDEX, FR_BAD_SEQ, FR_SHORT, FR_NOISE} frame_kind_t;

    typedef struct packed {
        bit        acc;
        bit [2:0]  rsn;
        bit [15:0] idx;
        bit [31:0] rseq;
        bit [31:0] eseq;
        bit [31:0] atot;
        bit [31:0] rtot;
    } verdict_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        command = 1'b0;
    logic [7:0]  data_byte = '0;
    logic        last = 1'b0;
    logic [31:0] new_sequence = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic        accepted;
    logic [2:0]  reject_reason;
    logic [15:0] security_index;
    logic [31:0] received_sequence;
    logic [31:0] expected_sequence;
    logic [31:0] accepted_total;
    logic [31:0] rejected_total;

    int items_sent = 0;
    int verdicts_seen = 0;
    bit quiet = 1'b0;
    bit hold = 1'b0;
    int stall_count = 0;

    hmac_frame_authenticator_unit dut (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic bit [31:0] ror32(input bit [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic bit [255:0] sha256_of(input bit [7:0] msg[$]);
        bit [31:0] h[8];
        bit [31:0] v[8];
        bit [31:0] w[64];
        bit [31:0] t1;
        bit [31:0] t2;
        bit [7:0]  m[$];
        bit [63:0] nbits;
        bit [255:0] dg;
        m = msg;
        nbits = 64'(m.size()) * 8;
        m.push_back(PAD_MARK);
        while (m.size() % 64 != 56)
            m.push_back(8'h00);
        for (int i = 0; i < 8; i++)
            m.push_back(nbits[63 - 8 * i -: 8]);
        for (int i = 0; i < 8; i++)
            h[i] = SHA_IV[i];
        for (int b = 0; b < m.size(); b += 64)
        begin
            for (int i = 0; i < 16; i++)
                w[i] = {m[b + 4 * i], m[b + 4 * i + 1], m[b + 4 * i + 2], m[b + 4 * i + 3]};
            for (int i = 16; i < 64; i++)
                w[i] = w[i - 16] + w[i - 7]
                     + (ror32(w[i - 15], 7) ^ ror32(w[i - 15], 18) ^ (w[i - 15] >> 3))
                     + (ror32(w[i - 2], 17) ^ ror32(w[i - 2], 19) ^ (w[i - 2] >> 10));
            v = h;
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                   + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + w[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                   + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
                v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                h[i] += v[i];
        end
        for (int i = 0; i < 8; i++)
            dg[255 - 32 * i -: 32] = h[i];
        return dg;
    endfunction

    // Truncated HMAC: the first 16 bytes of the outer digest, first byte in the top bits.
    function automatic bit [127:0] frame_tag(input bit [127:0] key, input bit [7:0] msg[$]);
        bit [7:0]   inner_msg[$];
        bit [7:0]   outer_msg[$];
        bit [7:0]   kb;
        bit [255:0] inner;
        bit [255:0] outer;
        for (int i = 0; i < 64; i++)
        begin
            kb = (i < 16) ? key[127 - 8 * i -: 8] : 8'h00;
            inner_msg.push_back(kb ^ IPAD);
            outer_msg.push_back(kb ^ OPAD);
        end
        foreach (msg[i])
            inner_msg.push_back(msg[i]);
        inner = sha256_of(inner_msg);
        for (int i = 0; i < 32; i++)
            outer_msg.push_back(inner[255 - 8 * i -: 8]);
        outer = sha256_of(outer_msg);
        return outer[255:128];
    endfunction

    class verdict_scoreboard;
        bit [63:0] key_hi;
        bit [63:0] key_lo;
        bit [31:0] window;
        bit [31:0] seq_exp;
        bit [31:0] acc_cnt;
        bit [31:0] rej_cnt;
        bit        overlong;
        bit [7:0]  frame[$];
        verdict_t  pending_verdicts[$];
        int        errors;

        function void set_reg(input bit [1:0] idx, input bit [63:0] val);
            case (idx)
                CFG_KEY_HIGH:   key_hi = val;
                CFG_KEY_LOW:    key_lo = val;
                CFG_SEQ_WINDOW: window = val[31:0];
                default:        ;
            endcase
        endfunction

        function void note_request(input bit cmd, input bit [7:0] b, input bit lst,
                                   input bit [31:0] ns);
            verdict_t   v;
            bit [7:0]   msg[$];
            bit [127:0] tag;
            int         n;
            if (cmd)
            begin
                seq_exp = ns;
                return;
            end
            if (frame.size() >= FRAME_LIMIT)
                overlong = 1'b1;
            else
                frame.push_back(b);
            if (!lst)
                return;
            n = frame.size();
            v.idx = 0;
            v.rseq = 0;
            for (int i = 0; i < n && i < 2; i++)
                v.idx = {v.idx[7:0], frame[i]};
            for (int i = 2; i < n && i < HDR_BYTES; i++)
                v.rseq = {v.rseq[23:0], frame[i]};
            if (n < MIN_FRAME)
                v.rsn = RSN_SHORT;
            else if (overlong)
                v.rsn = RSN_LONG;
            else
            begin
                for (int i = 0; i < n - TAG_LEN; i++)
                    msg.push_back(frame[i]);
                for (int i = 0; i < TAG_LEN; i++)
                    tag[127 - 8 * i -: 8] = frame[n - TAG_LEN + i];
                if (frame_tag({key_hi, key_lo}, msg) != tag)
                    v.rsn = RSN_TAG;
                else if (v.idx != 0)
                    v.rsn = RSN_INDEX;
                else if (v.rseq - seq_exp > window)
                    v.rsn = RSN_SEQ;
                else
                    v.rsn = RSN_OK;
            end
            v.acc = (v.rsn == RSN_OK);
            if (v.acc)
            begin
                seq_exp = v.rseq + 1;
                acc_cnt++;
            end
            else
                rej_cnt++;
            v.eseq = seq_exp;
            v.atot = acc_cnt;
            v.rtot = rej_cnt;
            pending_verdicts.push_back(v);
            frame.delete();
            overlong = 1'b0;
        endfunction

        function void check_verdict(input verdict_t got);
            verdict_t e;
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: verdict with none expected (reason %0d)", got.rsn);
                return;
            end
            e = pending_verdicts.pop_front();
            if (got != e)
            begin
                errors++;
                if (errors <= 10)
                    $display({"ERROR: verdict mismatch exp acc=%0d rsn=%0d idx=%h rseq=%h",
                              " eseq=%h atot=%0d rtot=%0d, got acc=%0d rsn=%0d idx=%h",
                              " rseq=%h eseq=%h atot=%0d rtot=%0d"},
                             e.acc, e.rsn, e.idx, e.rseq, e.eseq, e.atot, e.rtot,
                             got.acc, got.rsn, got.idx, got.rseq, got.eseq, got.atot, got.rtot);
            end
        endfunction
    endclass

    verdict_scoreboard sb = new();

    // Sender: one request per call; returns right after the edge that took it.
    task automatic send_request(input bit cmd, input bit [7:0] b, input bit lst,
                                input bit [31:0] ns);
        bit taken;
        if (!quiet && $urandom_range(0, 99) < 27)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid     <= 1'b1;
        command      <= cmd;
        data_byte    <= b;
        last         <= lst;
        new_sequence <= ns;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        sb.note_request(cmd, b, lst, ns);
        items_sent++;
    endtask

    task automatic send_frame(input frame_kind_t kind, input int plen);
        bit [7:0]   bytes[$];
        bit [15:0]  idx;
        bit [31:0]  seq;
        bit [127:0] tag;
        int         n;
        if (kind == FR_SHORT || kind == FR_NOISE)
        begin
            n = (kind == FR_SHORT) ? $urandom_range(1, MIN_FRAME - 1) : MIN_FRAME + plen;
            repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
        end
        else
        begin
            idx = (kind == FR_BAD_INDEX) ? 16'($urandom_range(1, 65535)) : 16'h0000;
            if (kind == FR_BAD_SEQ && sb.window != 32'hFFFF_FFFF)
                seq = sb.seq_exp + $urandom_range(sb.window + 1, 32'hFFFF_FFFF);
            else if ($urandom_range(0, 3) == 0)
                seq = sb.seq_exp + sb.window;
            else
                seq = sb.seq_exp + $urandom_range(0, (sb.window < 8) ? sb.window : 8);
            bytes = '{idx[15:8], idx[7:0], seq[31:24], seq[23:16], seq[15:8], seq[7:0]};
            repeat (plen) bytes.push_back(8'($urandom_range(0, 255)));
            tag = frame_tag({sb.key_hi, sb.key_lo}, bytes);
            if (kind == FR_BAD_TAG)
                tag[$urandom_range(0, 127)] ^= 1'b1;
            for (int i = 0; i < TAG_LEN; i++)
                bytes.push_back(tag[127 - 8 * i -: 8]);
        end
        foreach (bytes[i])
            send_request(1'b0, bytes[i], i == bytes.size() - 1, $urandom);
    endtask

    task automatic write_reg(input bit [1:0] idx, input bit [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        sb.set_reg(idx, val);
    endtask

    // Idle the sender and wait until every verdict is back and the engine has settled.
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic random_frames(input int upto, input bit with_overlong);
        int pick;
        int plen;
        frame_kind_t kind;
        while (items_sent < upto)
        begin
            quiet = (items_sent >= 800 && items_sent < 1100);
            if (with_overlong)
            begin
                send_frame(FR_GOOD, FRAME_LIMIT);
                with_overlong = 1'b0;
            end
            pick = $urandom_range(0, 99);
            if (pick < 6)
            begin
                send_request(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                             $urandom);
                continue;
            end
            plen = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 260)
                                               : $urandom_range(0, 50);
            if (pick < 60)      kind = FR_GOOD;
            else if (pick < 68) kind = FR_BAD_TAG;
            else if (pick < 76) kind = FR_BAD_INDEX;
            else if (pick < 84) kind = FR_BAD_SEQ;
            else if (pick < 92) kind = FR_SHORT;
            else                kind = FR_NOISE;
            send_frame(kind, plen);
        end
    endtask

    always @(posedge clk)
    begin
        out_ready <= hold ? 1'b0 : (quiet ? 1'b1 : ($urandom_range(0, 99) >= 27));
    end

    // Long receiver stall so the verdict register fills and byte intake backs up.
    initial
    begin
        wait (verdicts_seen >= 10);
        @(posedge clk);
        hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold = 1'b0;
    end

    always @(negedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && out_ready)
        begin
            v.acc  = accepted;
            v.rsn  = reject_reason;
            v.idx  = security_index;
            v.rseq = received_sequence;
            v.eseq = expected_sequence;
            v.atot = accepted_total;
            v.rtot = rejected_total;
            sb.check_verdict(v);
            verdicts_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= STALL_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with zero key and zero window.
        send_frame(FR_GOOD, 0);
        send_request(1'b1, 8'hFF, 1'b1, 32'hFFFF_FFFF);
        send_frame(FR_GOOD, 1);
        send_request(1'b0, 8'h00, 1'b1, 32'hFFFF_FFFF);
        send_frame(FR_SHORT, 0);
        send_frame(FR_BAD_TAG, 0);
        send_frame(FR_BAD_INDEX, 0);
        send_frame(FR_BAD_SEQ, 0);
        // A set request in the middle of a frame must not disturb it.
        send_request(1'b0, 8'h00, 1'b0, 32'h0);
        send_request(1'b1, 8'h00, 1'b0, 32'h0000_0010);
        send_request(1'b0, 8'hFF, 1'b1, 32'h0);
        drain();

        write_reg(CFG_KEY_HIGH, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_KEY_LOW, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(CFG_SEQ_WINDOW, 64'h0000_0000_FFFF_FFFF);
        write_reg(CFG_UNUSED, 64'h0123_4567_89AB_CDEF);
        random_frames(300, 1'b0);
        drain();

        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_SEQ_WINDOW, 64'h0);
        random_frames(700, 1'b0);
        drain();

        write_reg(CFG_KEY_HIGH, {$urandom, $urandom});
        write_reg(CFG_KEY_LOW, 64'h0);
        write_reg(CFG_SEQ_WINDOW, {32'h0, $urandom});
        random_frames(1100, 1'b0);
        drain();

        write_reg(CFG_KEY_HIGH, 64'h0);
        write_reg(CFG_KEY_LOW, {$urandom, $urandom});
        write_reg(CFG_SEQ_WINDOW, 64'($urandom_range(1, 20)));
        random_frames(RANDOM_ITEMS, 1'b0);
        drain();

        if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/hfa_pkg.sv
hw/rtl/hfa_ctrl.sv
hw/rtl/hfa_datapath.sv
hw/rtl/hmac_frame_authenticator_unit.sv
hw/rtl/hfa_checker.sv
tb/sv/tb_top.sv
